/* rtl/xfr_pkg.sv */
// ----------------------------------------------------------------------------
// xfr_pkg
// Shared codes, constants and types of the frame receiver and link monitor.
// ----------------------------------------------------------------------------
package xfr_pkg;

    localparam logic [7:0] SofByte      = 8'hAB;
    localparam logic [7:0] KindHeartbt  = 8'h21;
    localparam logic [7:0] KindUsb      = 8'h20;
    localparam logic [7:0] KindLog      = 8'h10;

    localparam logic [2:0] EvNone       = 3'd0;
    localparam logic [2:0] EvHeartbeat  = 3'd1;
    localparam logic [2:0] EvUsb        = 3'd2;
    localparam logic [2:0] EvLog        = 3'd3;
    localparam logic [2:0] EvUnknown    = 3'd4;
    localparam logic [2:0] EvMismatch   = 3'd5;

    localparam logic       CfgTimeout   = 1'b0;
    localparam logic       CfgNotify    = 1'b1;

    localparam logic [31:0] TimeoutReset = 32'd3000;
    localparam logic [31:0] AgeMax       = 32'hFFFF_FFFF;

    localparam int QDepth = 2;
    localparam int QAw    = 1;
    localparam int QCw    = 2;

    typedef struct packed {
        logic       tick;
        logic [2:0] ev;
        logic       usb_upd;
        logic       mnt;
        logic       susp;
    } t_cls;

endpackage

/* rtl/xfr_front.sv */
// ----------------------------------------------------------------------------
// xfr_front
// Frame parser: tracks the frame phase and check byte, classifies each item.
// ----------------------------------------------------------------------------
module xfr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic                i_func,
    input  logic [7:0]          i_rx_byte,
    output xfr_pkg::t_cls       o_cls
);

    localparam logic [2:0] PhIdle  = 3'd0;
    localparam logic [2:0] PhKind  = 3'd1;
    localparam logic [2:0] PhLen   = 3'd2;
    localparam logic [2:0] PhData  = 3'd3;
    localparam logic [2:0] PhCheck = 3'd4;

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_kind, n_kind;
    logic [7:0] r_len, n_len;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_cnt, n_cnt;
    logic [1:0] r_fpb, n_fpb;
    logic [7:0] cnt_inc;

    assign cnt_inc = r_cnt + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_len   = r_len;
        n_xor   = r_xor;
        n_cnt   = r_cnt;
        n_fpb   = r_fpb;
        o_cls.tick    = i_func;
        o_cls.ev      = xfr_pkg::EvNone;
        o_cls.usb_upd = (r_len != 8'd0);
        o_cls.mnt     = r_fpb[0];
        o_cls.susp    = r_fpb[1];
        if (!i_func) begin
            case (r_phase)
                PhKind: begin
                    n_kind  = i_rx_byte;
                    n_xor   = i_rx_byte;
                    n_phase = PhLen;
                end
                PhLen: begin
                    n_len   = i_rx_byte;
                    n_xor   = r_xor ^ i_rx_byte;
                    n_cnt   = 8'd0;
                    n_fpb   = 2'd0;
                    n_phase = (i_rx_byte == 8'd0) ? PhCheck : PhData;
                end
                PhData: begin
                    if (r_cnt == 8'd0) begin
                        n_fpb = i_rx_byte[1:0];
                    end
                    n_xor = r_xor ^ i_rx_byte;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= r_len) begin
                        n_phase = PhCheck;
                    end
                end
                PhCheck: begin
                    if (i_rx_byte == r_xor) begin
                        if (r_kind == xfr_pkg::KindHeartbt) begin
                            o_cls.ev = xfr_pkg::EvHeartbeat;
                        end else if (r_kind == xfr_pkg::KindUsb) begin
                            o_cls.ev = xfr_pkg::EvUsb;
                        end else if (r_kind == xfr_pkg::KindLog) begin
                            o_cls.ev = xfr_pkg::EvLog;
                        end else begin
                            o_cls.ev = xfr_pkg::EvUnknown;
                        end
                    end else begin
                        o_cls.ev = xfr_pkg::EvMismatch;
                    end
                    n_phase = PhIdle;
                end
                default: begin
                    n_phase = (i_rx_byte == xfr_pkg::SofByte) ? PhKind : PhIdle;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PhIdle;
            r_kind  <= 8'd0;
            r_len   <= 8'd0;
            r_xor   <= 8'd0;
            r_cnt   <= 8'd0;
            r_fpb   <= 2'd0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_len   <= n_len;
            r_xor   <= n_xor;
            r_cnt   <= n_cnt;
            r_fpb   <= n_fpb;
        end
    end

endmodule

/* rtl/xfr_queue.sv */
// ----------------------------------------------------------------------------
// xfr_queue
// Two-entry queue of classified items between parser and link monitor.
// ----------------------------------------------------------------------------
module xfr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  xfr_pkg::t_cls       i_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output xfr_pkg::t_cls       o_data
);

    xfr_pkg::t_cls                  r_slot [xfr_pkg::QDepth];
    logic [xfr_pkg::QAw-1:0]        r_wp;
    logic [xfr_pkg::QAw-1:0]        r_rp;
    logic [xfr_pkg::QCw-1:0]        r_cnt;

    assign o_full  = (r_cnt == xfr_pkg::QCw'(xfr_pkg::QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/xfr_back.sv */
// ----------------------------------------------------------------------------
// xfr_back
// Link monitor: heartbeat age, usb status bits and the registered result.
// ----------------------------------------------------------------------------
module xfr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_timeout,
    input  logic                i_notify,
    input  logic                i_q_valid,
    input  xfr_pkg::t_cls       i_q_data,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_event_res,
    output logic                o_first_heartbeat,
    output logic                o_mount_changed,
    output logic                o_link_up,
    output logic                o_usb_mounted,
    output logic                o_usb_suspended
);

    logic        r_seen, n_seen;
    logic [31:0] r_age, n_age;
    logic        r_mnt, n_mnt;
    logic        r_susp, n_susp;
    logic        r_out_valid;
    logic [2:0]  r_ev;
    logic        r_first, r_chg, r_up, r_umnt, r_usus;
    logic        first, chg, up, is_hb;

    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);
    assign is_hb = (i_q_data.ev == xfr_pkg::EvHeartbeat);

    always_comb begin
        n_seen = r_seen | is_hb;
        n_mnt  = r_mnt;
        n_susp = r_susp;
        chg    = 1'b0;
        first  = is_hb && !r_seen;
        if (i_q_data.tick) begin
            n_age = (r_age != xfr_pkg::AgeMax) ? r_age + 32'd1 : r_age;
        end else if (is_hb) begin
            n_age = 32'd0;
        end else begin
            n_age = r_age;
        end
        if (i_q_data.ev == xfr_pkg::EvUsb && i_q_data.usb_upd) begin
            n_mnt  = i_q_data.mnt;
            n_susp = i_q_data.susp;
            chg    = i_notify && (i_q_data.mnt != r_mnt);
        end
        up = n_seen && (n_age < i_timeout);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_age       <= 32'd0;
            r_mnt       <= 1'b0;
            r_susp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_seen <= n_seen;
                r_age  <= n_age;
                r_mnt  <= n_mnt;
                r_susp <= n_susp;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ev    <= i_q_data.ev;
            r_first <= first;
            r_chg   <= chg;
            r_up    <= up;
            r_umnt  <= up & n_mnt;
            r_usus  <= up & n_susp;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_res       = r_ev;
    assign o_first_heartbeat = r_first;
    assign o_mount_changed   = r_chg;
    assign o_link_up         = r_up;
    assign o_usb_mounted     = r_umnt;
    assign o_usb_suspended   = r_usus;

endmodule

/* rtl/xor_frame_receiver_link_monitor.sv */
// ----------------------------------------------------------------------------
// xor_frame_receiver_link_monitor
// XOR-checked frame receiver with heartbeat link monitor.
// ----------------------------------------------------------------------------
// Takes one item per clock, a received byte or a time tick, and returns one
// result per item through a queue slot and the output register. The parser
// classifies each item as it is accepted and pushes it into a two-entry queue;
// the link monitor pops one entry per cycle into the output register, so a sustained
// rate of one item per cycle holds while the output is not stalled. The
// input stalls only when the queue is full.
module xor_frame_receiver_link_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_res,
    output logic        o_first_heartbeat,
    output logic        o_mount_changed,
    output logic        o_link_up,
    output logic        o_usb_mounted,
    output logic        o_usb_suspended,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0]        r_timeout;
    logic               r_notify;
    logic               take;
    logic               q_full;
    logic               q_valid;
    logic               pop;
    xfr_pkg::t_cls      f_cls;
    xfr_pkg::t_cls      q_data;

    assign o_in_stall = q_full;
    assign take       = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= xfr_pkg::TimeoutReset;
            r_notify  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                xfr_pkg::CfgTimeout: r_timeout <= i_cfg_data;
                xfr_pkg::CfgNotify:  r_notify  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    xfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_func    (i_func),
        .i_rx_byte (i_rx_byte),
        .o_cls     (f_cls)
    );

    xfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (f_cls),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    xfr_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_timeout         (r_timeout),
        .i_notify          (r_notify),
        .i_q_valid         (q_valid),
        .i_q_data          (q_data),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_event_res       (o_event_res),
        .o_first_heartbeat (o_first_heartbeat),
        .o_mount_changed   (o_mount_changed),
        .o_link_up         (o_link_up),
        .o_usb_mounted     (o_usb_mounted),
        .o_usb_suspended   (o_usb_suspended)
    );

    a_first_is_hb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_first_heartbeat) |-> (o_event_res == xfr_pkg::EvHeartbeat))
        else $error("first heartbeat flag on a non-heartbeat result");

    a_chg_is_usb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mount_changed) |-> (o_event_res == xfr_pkg::EvUsb))
        else $error("mount change flag on a non-usb result");

    a_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_usb_mounted || o_usb_suspended)) |-> o_link_up)
        else $error("usb status shown while link down");

    a_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_valid)
        else $error("input stalled with empty queue");

endmodule

/* tb/sv/tb_xor_frame_receiver_link_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xor_frame_receiver_link_monitor
// Self-checking bench for the frame receiver and link monitor. A short table
// of bytes and ticks opens the run, then random framed traffic with noise,
// broken frames, bad check bytes and tick bursts runs under several timeout
// and notify settings and flow-control patterns. Each result is checked field by
// field against the pinned table entry or a bench-side parser and link model.
// ----------------------------------------------------------------------------
module tb_xor_frame_receiver_link_monitor;

    typedef struct packed {
        logic [2:0] ev;
        logic       first_hb;
        logic       mount_chg;
        logic       up;
        logic       mounted;
        logic       suspended;
    } t_link_result;

    typedef struct packed {
        logic         func;
        logic [7:0]   data;
        logic         pinned;
        t_link_result want;
    } t_link_req;

    typedef enum logic [2:0] {HUNT, GET_KIND, GET_LEN, GET_DATA, GET_CHECK} t_parse_step;
    typedef enum int {FLOW_OPEN, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH_IDLE} t_flow_mode;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;
    localparam logic PIN       = 1'b1;
    localparam logic FREE      = 1'b0;
    localparam int   QUIET_LIMIT = 4000;
    localparam int   REPORT_CAP  = 100;

    localparam t_link_result W_DOWN     = {xfr_pkg::EvNone,      5'b00000};
    localparam t_link_result W_FIRST_HB = {xfr_pkg::EvHeartbeat, 5'b10100};
    localparam t_link_result W_USB_ON   = {xfr_pkg::EvUsb,       5'b00111};
    localparam t_link_result W_LOG      = {xfr_pkg::EvLog,       5'b00111};
    localparam t_link_result W_BAD      = {xfr_pkg::EvMismatch,  5'b00111};

    t_link_req opening_rows [26] = '{
        {FUNC_TICK, 8'h5A,                FREE, W_DOWN},
        {FUNC_BYTE, 8'hFF,                PIN,  W_DOWN},
        {FUNC_BYTE, xfr_pkg::SofByte,     FREE, W_DOWN},
        {FUNC_BYTE, xfr_pkg::KindHeartbt, FREE, W_DOWN},
        {FUNC_TICK, 8'hFF,                PIN,  W_DOWN},
        {FUNC_BYTE, 8'h00,                FREE, W_DOWN},
        {FUNC_BYTE, 8'h21,                PIN,  W_FIRST_HB},
        {FUNC_BYTE, xfr_pkg::SofByte,     FREE, W_DOWN},
        {FUNC_BYTE, xfr_pkg::KindUsb,     FREE, W_DOWN},
        {FUNC_BYTE, 8'h01,                FREE, W_DOWN},
        {FUNC_BYTE, 8'h03,                FREE, W_DOWN},
        {FUNC_BYTE, 8'h22,                PIN,  W_USB_ON},
        {FUNC_BYTE, xfr_pkg::SofByte,     FREE, W_DOWN},
        {FUNC_BYTE, xfr_pkg::KindUsb,     FREE, W_DOWN},
        {FUNC_BYTE, 8'h00,                FREE, W_DOWN},
        {FUNC_BYTE, 8'h20,                PIN,  W_USB_ON},
        {FUNC_BYTE, xfr_pkg::SofByte,     FREE, W_DOWN},
        {FUNC_BYTE, xfr_pkg::KindLog,     FREE, W_DOWN},
        {FUNC_BYTE, 8'h02,                FREE, W_DOWN},
        {FUNC_BYTE, 8'hFF,                FREE, W_DOWN},
        {FUNC_BYTE, 8'h00,                FREE, W_DOWN},
        {FUNC_BYTE, 8'hED,                PIN,  W_LOG},
        {FUNC_BYTE, xfr_pkg::SofByte,     FREE, W_DOWN},
        {FUNC_BYTE, 8'hFF,                FREE, W_DOWN},
        {FUNC_BYTE, 8'h00,                FREE, W_DOWN},
        {FUNC_BYTE, 8'h00,                PIN,  W_BAD}
    };

    logic [31:0] phase_timeout [6] = '{32'd40, 32'd5, 32'd0, 32'd1, xfr_pkg::AgeMax, 32'd12};
    logic        phase_notify  [6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    t_flow_mode  phase_flow    [6] = '{FLOW_OPEN, FLOW_SEND_GAPS, FLOW_RECV_STALLS,
                                       FLOW_BOTH_IDLE, FLOW_OPEN, FLOW_BOTH_IDLE};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        func      = FUNC_BYTE;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_res;
    logic        first_heartbeat;
    logic        mount_changed;
    logic        link_up;
    logic        usb_mounted;
    logic        usb_suspended;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = xfr_pkg::CfgTimeout;
    logic [31:0] cfg_data  = 32'd0;

    // bench-side copy of the parser, link state and registers
    t_parse_step parse_at    = HUNT;
    logic [7:0]  frame_kind  = 8'h00;
    logic [7:0]  frame_len   = 8'h00;
    logic [7:0]  fcs_acc     = 8'h00;
    logic [7:0]  data_seen   = 8'h00;
    logic [7:0]  lead_byte   = 8'h00;
    logic        hb_seen     = 1'b0;
    logic [31:0] hb_age      = 32'd0;
    logic        mounted     = 1'b0;
    logic        suspended   = 1'b0;
    logic [31:0] timeout_cfg = xfr_pkg::TimeoutReset;
    logic        notify_cfg  = 1'b0;

    t_link_req    pending_reqs[$];
    t_link_result awaited_results[$];
    t_link_req    offered;
    bit           offer_open   = 1'b0;
    t_flow_mode   flow         = FLOW_OPEN;
    int           quiet_cycles = 0;
    int           fail_count   = 0;
    int           queued_total = 0;
    int           sent_total   = 0;
    int           down_total   = 0;
    int           ev_tally [8] = '{default: 0};

    xor_frame_receiver_link_monitor uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_func            (func),
        .i_rx_byte         (rx_byte),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_event_res       (event_res),
        .o_first_heartbeat (first_heartbeat),
        .o_mount_changed   (mount_changed),
        .o_link_up         (link_up),
        .o_usb_mounted     (usb_mounted),
        .o_usb_suspended   (usb_suspended),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        fail_count++;
        if (fail_count <= REPORT_CAP) $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [2:0] got, input logic [2:0] want);
        if (got !== want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic predict_link_result(input logic f, input logic [7:0] b,
                                       output t_link_result r);
        r = W_DOWN;
        if (f == FUNC_TICK) begin
            if (hb_age != xfr_pkg::AgeMax) hb_age++;
        end else begin
            case (parse_at)
                GET_KIND: begin
                    frame_kind = b;
                    fcs_acc    = b;
                    parse_at   = GET_LEN;
                end
                GET_LEN: begin
                    frame_len = b;
                    fcs_acc   ^= b;
                    data_seen = 8'h00;
                    lead_byte = 8'h00;
                    parse_at  = (b == 8'h00) ? GET_CHECK : GET_DATA;
                end
                GET_DATA: begin
                    if (data_seen == 8'h00) lead_byte = b;
                    fcs_acc ^= b;
                    data_seen++;
                    if (data_seen >= frame_len) parse_at = GET_CHECK;
                end
                GET_CHECK: begin
                    if (b != fcs_acc) begin
                        r.ev = xfr_pkg::EvMismatch;
                    end else if (frame_kind == xfr_pkg::KindHeartbt) begin
                        r.ev       = xfr_pkg::EvHeartbeat;
                        r.first_hb = !hb_seen;
                        hb_seen    = 1'b1;
                        hb_age     = 32'd0;
                    end else if (frame_kind == xfr_pkg::KindUsb) begin
                        r.ev = xfr_pkg::EvUsb;
                        if (frame_len != 8'h00) begin
                            r.mount_chg = notify_cfg && (mounted != lead_byte[0]);
                            mounted     = lead_byte[0];
                            suspended   = lead_byte[1];
                        end
                    end else if (frame_kind == xfr_pkg::KindLog) begin
                        r.ev = xfr_pkg::EvLog;
                    end else begin
                        r.ev = xfr_pkg::EvUnknown;
                    end
                    parse_at = HUNT;
                end
                default: begin
                    parse_at = (b == xfr_pkg::SofByte) ? GET_KIND : HUNT;
                end
            endcase
        end
        r.up        = hb_seen && (hb_age < timeout_cfg);
        r.mounted   = r.up & mounted;
        r.suspended = r.up & suspended;
    endtask

    always @(posedge clk) begin : handshake_engine
        t_link_result got;
        t_link_result want;
        t_link_result model;
        bit           progress;

        progress = 1'b0;
        if (out_valid && !out_stall) begin
            progress = 1'b1;
            got = {event_res, first_heartbeat, mount_changed, link_up, usb_mounted,
                   usb_suspended};
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("result with none pending, event_res %0d", event_res));
            end else begin
                want = awaited_results.pop_front();
                check_field("event_res", got.ev, want.ev);
                check_field("first_heartbeat", 3'(got.first_hb), 3'(want.first_hb));
                check_field("mount_changed", 3'(got.mount_chg), 3'(want.mount_chg));
                check_field("link_up", 3'(got.up), 3'(want.up));
                check_field("usb_mounted", 3'(got.mounted), 3'(want.mounted));
                check_field("usb_suspended", 3'(got.suspended), 3'(want.suspended));
            end
        end
        if (in_valid && !in_stall) begin
            progress = 1'b1;
            predict_link_result(offered.func, offered.data, model);
            ev_tally[model.ev]++;
            if (hb_seen && !model.up) down_total++;
            awaited_results.push_back(offered.pinned ? offered.want : model);
            sent_total++;
            offer_open = 1'b0;
        end
        if (!(in_valid && in_stall)) begin
            if (rst_n && pending_reqs.size() != 0
                && !(flow == FLOW_SEND_GAPS && $urandom_range(99) < 78)
                && !(flow == FLOW_BOTH_IDLE && $urandom_range(99) < 26)) begin
                offered    = pending_reqs.pop_front();
                offer_open = 1'b1;
                in_valid   <= 1'b1;
                func       <= offered.func;
                rx_byte    <= offered.data;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= (flow == FLOW_RECV_STALLS && $urandom_range(99) < 78)
                  || (flow == FLOW_BOTH_IDLE && $urandom_range(99) < 26);
        quiet_cycles = progress ? 0 : quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic push_req(input logic f, input logic [7:0] d);
        pending_reqs.push_back({f, d, FREE, W_DOWN});
        queued_total++;
    endtask

    task automatic push_link_byte(input logic [7:0] d);
        if ($urandom_range(99) < 15) push_req(FUNC_TICK, 8'($urandom_range(255)));
        push_req(FUNC_BYTE, d);
    endtask

    task automatic queue_frame(input logic [7:0] kind, input int len, input bit corrupt);
        logic [7:0] fcs;
        logic [7:0] b;

        push_link_byte(xfr_pkg::SofByte);
        push_link_byte(kind);
        push_link_byte(len[7:0]);
        fcs = kind ^ len[7:0];
        repeat (len) begin
            b = 8'($urandom_range(255));
            fcs ^= b;
            push_link_byte(b);
        end
        if (corrupt) fcs ^= 8'($urandom_range(255, 1));
        push_link_byte(fcs);
    endtask

    task automatic queue_random_traffic(input int budget);
        int         goal;
        int         roll;
        int         len;
        logic [7:0] kind;

        goal = queued_total + budget;
        while (queued_total < goal) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                push_req(FUNC_BYTE, 8'($urandom_range(255)));
            end else if (roll < 10) begin
                repeat ($urandom_range(12, 1)) push_req(FUNC_TICK, 8'($urandom_range(255)));
            end else if (roll < 14) begin
                push_link_byte(xfr_pkg::SofByte);
                push_link_byte(8'($urandom_range(255)));
            end else begin
                case ($urandom_range(9))
                    0, 1, 2, 3: kind = xfr_pkg::KindHeartbt;
                    4, 5, 6:    kind = xfr_pkg::KindUsb;
                    7:          kind = xfr_pkg::KindLog;
                    default:    kind = 8'($urandom_range(255));
                endcase
                len = (kind == xfr_pkg::KindUsb) ? $urandom_range(2) : $urandom_range(3);
                if ($urandom_range(19) == 0) len = $urandom_range(40, 4);
                queue_frame(kind, len, $urandom_range(9) == 0);
            end
        end
    endtask

    task automatic drain_link();
        while (pending_reqs.size() != 0 || offer_open || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == xfr_pkg::CfgTimeout) timeout_cfg = val;
        else notify_cfg = val[0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : run_sequence
        int p;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        foreach (opening_rows[k]) pending_reqs.push_back(opening_rows[k]);
        drain_link();
        for (p = 0; p < 6; p++) begin
            write_cfg(xfr_pkg::CfgTimeout, phase_timeout[p]);
            write_cfg(xfr_pkg::CfgNotify, {31'd0, phase_notify[p]});
            flow = phase_flow[p];
            queue_random_traffic(20);
            if (p == 4) queue_frame(xfr_pkg::KindHeartbt, 255, 1'b0);
            // hold the sender until the block is empty
            drain_link();
            queue_random_traffic(20);
            drain_link();
        end
        repeat (6) @(posedge clk);
        $display("Covered %0d requests over 7 settings and 4 flow patterns", sent_total);
        $display("Frames: %0d heartbeat, %0d usb, %0d log, %0d unknown, %0d bad check; %0d link down",
                 ev_tally[xfr_pkg::EvHeartbeat], ev_tally[xfr_pkg::EvUsb],
                 ev_tally[xfr_pkg::EvLog], ev_tally[xfr_pkg::EvUnknown],
                 ev_tally[xfr_pkg::EvMismatch], down_total);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
